// ----- hdl/pqrt_pkg.sv -----
// Package for the pacing queue rate tracker.
// Holds command and status codes and the slot record layout; no dependencies.
package pqrt_pkg;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_SENT  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DUP      = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	localparam int SEQ_W   = 32;
	localparam int BYTES_W = 16;
	localparam int TS_W    = 48;
	localparam int TOTAL_W = 24;
	localparam int SLOT_W  = SEQ_W + BYTES_W + TS_W;
	localparam int DVD_W   = TOTAL_W + 3;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX     = '1;
	localparam logic [15:0]        STALE_WIN_MS  = 16'd500;
	localparam logic [15:0]        MIN_BUDGET_MS = 16'd2;
	localparam logic [15:0]        BUDGET_RESET  = 16'd2000;

endpackage

// ----- hdl/pacing_queue_rate_tracker_top.sv -----
// Top level of the pacing queue rate tracker: keyed slot table, insertion FIFO,
// scan sequencer and serial divider. Depends on pqrt_pkg and pqrt_ram.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in      | to block  | in_valid/in_stall  | command, seq_number, packet_bytes,
//          |           |                    | queue_ts, now_ms
//  out     | from block| out_valid/out_stall| status, front_valid, front_seq, ...
//  cfg     | to block  | cfg_write          | cfg_data (max_queue_ms)
//
// Every item runs a scan of all QUEUE_DEPTH slots through the slot RAM read port,
// one slot a cycle, then the execute state. A mark-sent that finds its key then
// retires sent FIFO head entries (S_RET_RD, S_RET_CK) and, if entries remain,
// loads the new head's timestamp (S_RET_TS); a query with bytes queued runs the
// restoring divider. The block takes one item at a time: in_stall is high from
// accept until the result item is taken. Reset clears valid and sent flags at once;
// no clearing pass.
module pacing_queue_rate_tracker_top
	import pqrt_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   command,
	input  logic [31:0]  seq_number,
	input  logic [15:0]  packet_bytes,
	input  logic [47:0]  queue_ts,
	input  logic [47:0]  now_ms,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [1:0]   status,
	output logic         front_valid,
	output logic [31:0]  front_seq,
	output logic [15:0]  front_bytes,
	output logic         queue_empty,
	output logic [23:0]  total_bytes,
	output logic [47:0]  oldest_ms,
	output logic [31:0]  target_kbps,
	input  logic         cfg_write,
	input  logic [15:0]  cfg_data
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] QD_C   = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W:0]   QD_W   = (CNT_W+1)'(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_I = IDX_W'(QUEUE_DEPTH - 1);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SCAN   = 8'b0000_0010,
		S_EXEC   = 8'b0000_0100,
		S_RET_RD = 8'b0000_1000,
		S_RET_CK = 8'b0001_0000,
		S_RET_TS = 8'b0010_0000,
		S_DIV    = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Captured item
	cmd_t         cmd_q;
	logic [31:0]  key_q;
	logic [15:0]  size_q;
	logic [47:0]  qts_q;
	logic [47:0]  now_q;
	logic [15:0]  budget_cfg_q;

	// Queue state
	logic [QUEUE_DEPTH-1:0] slot_valid_q;
	logic [QUEUE_DEPTH-1:0] slot_sent_q;
	logic [IDX_W-1:0]       head_q;
	logic [CNT_W-1:0]       count_q;
	logic [TOTAL_W-1:0]     total_q;
	logic [47:0]            stamp_q;
	logic                   known_q;

	// Scan results
	logic [CNT_W-1:0]  scan_cnt_q;
	logic              key_hit_q;
	logic [IDX_W-1:0]  key_idx_q;
	logic [15:0]       key_bytes_q;
	logic              free_hit_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              any_q;
	logic              best_hit_q;
	logic [31:0]       best_seq_q;
	logic [15:0]       best_bytes_q;

	// Divider
	logic [15:0]       space_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [15:0]       rem_q;
	logic [4:0]        div_cnt_q;

	// Result
	status_t      res_status_q;
	logic         res_fvalid_q;
	logic [31:0]  res_fseq_q;
	logic [15:0]  res_fbytes_q;
	logic         res_empty_q;
	logic [23:0]  res_total_q;
	logic [47:0]  res_oldest_q;
	logic [31:0]  res_kbps_q;

	// RAM ports
	logic              slot_we;
	logic [IDX_W-1:0]  slot_raddr;
	logic [SLOT_W-1:0] slot_rdata;
	logic              fifo_we;
	logic [IDX_W-1:0]  fifo_waddr;
	logic [IDX_W-1:0]  fifo_rdata;

	logic [31:0]       rd_seq;
	logic [15:0]       rd_bytes;
	logic [47:0]       rd_ts;
	logic [IDX_W-1:0]  proc_idx;
	logic              proc_valid;
	logic              proc_sent;
	logic [CNT_W:0]    tail_sum;
	logic [TOTAL_W:0]  add_sum;
	logic [15:0]       add_n;
	logic [15:0]       budget;
	logic [47:0]       elapsed;
	logic [16:0]       rem_shift;
	logic              div_take;
	logic [DVD_W-1:0]  dvd_next;
	logic              push_new;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	assign status      = res_status_q;
	assign front_valid = res_fvalid_q;
	assign front_seq   = res_fseq_q;
	assign front_bytes = res_fbytes_q;
	assign queue_empty = res_empty_q;
	assign total_bytes = res_total_q;
	assign oldest_ms   = res_oldest_q;
	assign target_kbps = res_kbps_q;

	assign rd_seq   = slot_rdata[SLOT_W-1 -: SEQ_W];
	assign rd_bytes = slot_rdata[TS_W +: BYTES_W];
	assign rd_ts    = slot_rdata[TS_W-1:0];

	// Slot being looked at this cycle: its read was issued in the previous cycle
	assign proc_idx   = IDX_W'(scan_cnt_q - CNT_W'(1));
	assign proc_valid = slot_valid_q[proc_idx];
	assign proc_sent  = slot_sent_q[proc_idx];

	always_comb begin
		tail_sum = {1'b0, CNT_W'(head_q)} + {1'b0, count_q};
		if (tail_sum >= QD_W) begin
			tail_sum = tail_sum - QD_W;
		end
	end
	assign fifo_waddr = IDX_W'(tail_sum);

	assign push_new = (state_q == S_EXEC) && (cmd_q == CMD_PUSH) && !key_hit_q
		&& free_hit_q && (count_q < QD_C);
	assign slot_we  = push_new;
	assign fifo_we  = push_new;

	always_comb begin
		if (state_q == S_RET_CK) begin
			slot_raddr = fifo_rdata;
		end else begin
			slot_raddr = IDX_W'(scan_cnt_q);
		end
	end

	assign add_n   = key_hit_q ? key_bytes_q : size_q;
	assign add_sum = {1'b0, total_q} + {{(TOTAL_W+1-16){1'b0}}, add_n};

	assign budget    = (budget_cfg_q < MIN_BUDGET_MS) ? MIN_BUDGET_MS : budget_cfg_q;
	assign elapsed   = now_q - stamp_q;
	assign rem_shift = {rem_q, dvd_q[DVD_W-1]};
	assign div_take  = (rem_shift >= {1'b0, space_q});
	assign dvd_next  = {dvd_q[DVD_W-2:0], div_take};

	pqrt_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_DEPTH)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (free_idx_q),
		.wdata ({key_q, size_q, qts_q}),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	pqrt_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_DEPTH)) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (fifo_waddr),
		.wdata (free_idx_q),
		.raddr (head_q),
		.rdata (fifo_rdata)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_cfg_q <= BUDGET_RESET;
		end else if (cfg_write) begin
			budget_cfg_q <= cfg_data;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q  <= cmd_t'(command);
			key_q  <= seq_number;
			size_q <= packet_bytes;
			qts_q  <= queue_ts;
			now_q  <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_valid_q <= '0;
			slot_sent_q  <= '0;
			head_q       <= '0;
			count_q      <= '0;
			total_q      <= '0;
			stamp_q      <= '0;
			known_q      <= 1'b0;
			scan_cnt_q   <= '0;
			key_hit_q    <= 1'b0;
			key_idx_q    <= '0;
			key_bytes_q  <= '0;
			free_hit_q   <= 1'b0;
			free_idx_q   <= '0;
			any_q        <= 1'b0;
			best_hit_q   <= 1'b0;
			best_seq_q   <= '0;
			best_bytes_q <= '0;
			space_q      <= '0;
			dvd_q        <= '0;
			rem_q        <= '0;
			div_cnt_q    <= '0;
			res_status_q <= ST_OK;
			res_fvalid_q <= 1'b0;
			res_fseq_q   <= '0;
			res_fbytes_q <= '0;
			res_empty_q  <= 1'b0;
			res_total_q  <= '0;
			res_oldest_q <= '0;
			res_kbps_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						scan_cnt_q   <= '0;
						key_hit_q    <= 1'b0;
						free_hit_q   <= 1'b0;
						any_q        <= 1'b0;
						best_hit_q   <= 1'b0;
						best_seq_q   <= '0;
						best_bytes_q <= '0;
						res_status_q <= ST_OK;
						res_fvalid_q <= 1'b0;
						res_fseq_q   <= '0;
						res_fbytes_q <= '0;
						res_empty_q  <= 1'b0;
						res_total_q  <= '0;
						res_oldest_q <= '0;
						res_kbps_q   <= '0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					// Evaluate the slot read last cycle; stop after the last one
					if (scan_cnt_q != '0) begin
						if (proc_valid) begin
							any_q <= 1'b1;
							if (!key_hit_q && rd_seq == key_q) begin
								key_hit_q   <= 1'b1;
								key_idx_q   <= proc_idx;
								key_bytes_q <= rd_bytes;
							end
							if (!proc_sent && (!best_hit_q || rd_seq < best_seq_q)) begin
								best_hit_q   <= 1'b1;
								best_seq_q   <= rd_seq;
								best_bytes_q <= rd_bytes;
							end
						end else if (!free_hit_q) begin
							free_hit_q <= 1'b1;
							free_idx_q <= proc_idx;
						end
					end
					if (scan_cnt_q == QD_C) begin
						state_q <= S_EXEC;
					end else begin
						scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					end
				end
				S_EXEC: begin
					state_q <= S_OUT;
					case (cmd_q)
						CMD_PUSH: begin
							if (!key_hit_q && !(free_hit_q && count_q < QD_C)) begin
								res_status_q <= ST_FULL;
							end else begin
								if (key_hit_q && !slot_sent_q[key_idx_q]) begin
									res_status_q <= ST_DUP;
								end else begin
									// New key or re-armed key: add bytes, saturate
									total_q <= (add_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
										: add_sum[TOTAL_W-1:0];
									if (key_hit_q) begin
										slot_sent_q[key_idx_q] <= 1'b0;
									end else begin
										slot_valid_q[free_idx_q] <= 1'b1;
										slot_sent_q[free_idx_q]  <= 1'b0;
										count_q <= count_q + CNT_W'(1);
									end
								end
								if (!known_q || stamp_q > qts_q) begin
									stamp_q <= qts_q;
									known_q <= 1'b1;
								end
							end
						end
						CMD_SENT: begin
							if (!key_hit_q) begin
								res_status_q <= ST_NOTFOUND;
							end else begin
								slot_sent_q[key_idx_q] <= 1'b1;
								total_q <= (total_q >= TOTAL_W'(key_bytes_q))
									? total_q - TOTAL_W'(key_bytes_q) : '0;
								state_q <= S_RET_RD;
							end
						end
						CMD_QUERY: begin
							res_fvalid_q <= best_hit_q;
							res_fseq_q   <= best_seq_q;
							res_fbytes_q <= best_bytes_q;
							res_empty_q  <= !any_q;
							res_total_q  <= total_q;
							res_oldest_q <= known_q ? stamp_q : now_q;
							if (known_q && now_q > stamp_q) begin
								if (elapsed >= 48'(budget)) begin
									space_q <= STALE_WIN_MS;
								end else begin
									space_q <= budget - elapsed[15:0];
								end
							end else begin
								space_q <= budget - 16'd1;
							end
							if (any_q && total_q != '0) begin
								dvd_q     <= {total_q, 3'b000};
								rem_q     <= '0;
								div_cnt_q <= '0;
								state_q   <= S_DIV;
							end
						end
						default: begin
						end
					endcase
				end
				S_RET_RD: begin
					// FIFO head read is issued here; data lands next cycle
					if (count_q == '0) begin
						slot_valid_q <= '0;
						slot_sent_q  <= '0;
						total_q      <= '0;
						known_q      <= 1'b0;
						stamp_q      <= '0;
						state_q      <= S_OUT;
					end else begin
						state_q <= S_RET_CK;
					end
				end
				S_RET_CK: begin
					if (slot_sent_q[fifo_rdata]) begin
						// Pop a sent head entry and free its slot
						slot_valid_q[fifo_rdata] <= 1'b0;
						slot_sent_q[fifo_rdata]  <= 1'b0;
						head_q  <= (head_q == LAST_I) ? '0 : head_q + IDX_W'(1);
						count_q <= count_q - CNT_W'(1);
						state_q <= S_RET_RD;
					end else begin
						state_q <= S_RET_TS;
					end
				end
				S_RET_TS: begin
					stamp_q <= rd_ts;
					known_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_DIV: begin
					// One restoring step per cycle; load the quotient on the last step
					if (div_take) begin
						rem_q <= 16'(rem_shift - {1'b0, space_q});
					end else begin
						rem_q <= rem_shift[15:0];
					end
					dvd_q <= dvd_next;
					if (div_cnt_q == 5'(DVD_W - 1)) begin
						res_kbps_q <= 32'(dvd_next);
						state_q    <= S_OUT;
					end else begin
						div_cnt_q <= div_cnt_q + 5'd1;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QD_C)
		else $error("entry count above depth");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(slot_valid_q) == 32'(count_q)))
		else $error("valid slots disagree with FIFO count");

	a_sent_subset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((slot_sent_q & ~slot_valid_q) == '0))
		else $error("sent flag on a free slot");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result waits");

endmodule

// ----- hdl/pqrt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pqrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- tb/pacing_queue_rate_tracker_top_tb.sv -----
// Testbench for the pacing queue rate tracker: directed table, table-full and hold-off runs, then random traffic,
// each result checked against an in-bench model of the queue. Depends on pqrt_pkg.
module pacing_queue_rate_tracker_top_tb;
	import pqrt_pkg::*;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		cmd_t        cmd;
		logic [31:0] seq;
		logic [15:0] nbytes;
		logic [47:0] qts;
		logic [47:0] now;
	} pkt_cmd_t;

	typedef struct {
		status_t     st;
		logic        fv;
		logic [31:0] fseq;
		logic [15:0] fbytes;
		logic        empty;
		logic [23:0] total;
		logic [47:0] oldest;
		logic [31:0] kbps;
	} queue_view_t;

	// directed row: command plus an optional typed-in expectation
	typedef struct {
		pkt_cmd_t    c;
		logic        fixed;
		queue_view_t v;
	} dir_row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  command = '0;
	logic [31:0] seq_number = '0;
	logic [15:0] packet_bytes = '0;
	logic [47:0] queue_ts = '0;
	logic [47:0] now_ms = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  status;
	logic        front_valid;
	logic [31:0] front_seq;
	logic [15:0] front_bytes;
	logic        queue_empty;
	logic [23:0] total_bytes;
	logic [47:0] oldest_ms;
	logic [31:0] target_kbps;
	logic        cfg_write = 0;
	logic [15:0] cfg_data = '0;

	pacing_queue_rate_tracker_top #(.QUEUE_DEPTH(DEPTH)) uut (.*);

	always #5 clk = ~clk;

	// model state of the queue
	logic        m_valid [DEPTH];
	logic        m_sent [DEPTH];
	logic [31:0] m_seq [DEPTH];
	logic [15:0] m_bytes [DEPTH];
	logic [47:0] m_ts [DEPTH];
	int          m_fifo [DEPTH];
	int          m_head, m_count;
	logic [23:0] m_total;
	logic [47:0] m_oldest;
	logic        m_known;
	logic [15:0] m_budget;

	queue_view_t pending_views [$];
	int errors = 0;
	int cycles = 0;
	bit rx_quiet = 0;      // no stalls at the end of the run
	bit long_hold = 0;     // receiver holds off for a long stretch

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic int find_seq(logic [31:0] k);
		for (int i = 0; i < DEPTH; i++)
			if (m_valid[i] && m_seq[i] == k) return i;
		return -1;
	endfunction

	function automatic void add_total(logic [15:0] n);
		logic [24:0] t;
		t = m_total + n;
		m_total = t > {1'b0, TOTAL_MAX} ? TOTAL_MAX : t[23:0];
	endfunction

	function automatic void lower_oldest(logic [47:0] ts);
		if (!m_known || m_oldest > ts) begin
			m_oldest = ts;
			m_known = 1;
		end
	endfunction

	function automatic void clear_queue();
		for (int i = 0; i < DEPTH; i++) begin
			m_valid[i] = 0;
			m_sent[i] = 0;
		end
		m_head = 0;
		m_count = 0;
		m_total = 0;
		m_oldest = 0;
		m_known = 0;
	endfunction

	// advance the model by one item and return the view it produces
	function automatic queue_view_t predict_view(pkt_cmd_t c);
		queue_view_t v;
		int k, f, s;
		logic [31:0] bud, space;
		logic [47:0] el;
		bit any;
		v = '{ST_OK, 0, 0, 0, 0, 0, 0, 0};
		case (c.cmd)
			CMD_PUSH: begin
				k = find_seq(c.seq);
				if (k < 0) begin
					f = -1;
					for (int i = DEPTH - 1; i >= 0; i--)
						if (!m_valid[i]) f = i;
					if (f < 0 || m_count >= DEPTH) begin
						v.st = ST_FULL;
						return v;
					end
					m_valid[f] = 1;
					m_sent[f] = 0;
					m_seq[f] = c.seq;
					m_bytes[f] = c.nbytes;
					m_ts[f] = c.qts;
					m_fifo[(m_head + m_count) % DEPTH] = f;
					m_count++;
					add_total(c.nbytes);
				end else if (m_sent[k]) begin
					m_sent[k] = 0;
					add_total(m_bytes[k]);
				end else
					v.st = ST_DUP;
				lower_oldest(c.qts);
			end
			CMD_SENT: begin
				k = find_seq(c.seq);
				if (k < 0) begin
					v.st = ST_NOTFOUND;
					return v;
				end
				m_sent[k] = 1;
				m_total = m_total >= m_bytes[k] ? m_total - m_bytes[k] : '0;
				// retire sent entries from the head
				while (m_count > 0) begin
					s = m_fifo[m_head];
					if (!m_sent[s]) break;
					m_valid[s] = 0;
					m_sent[s] = 0;
					m_head = (m_head + 1) % DEPTH;
					m_count--;
				end
				if (m_count == 0) clear_queue();
				else begin
					m_oldest = m_ts[m_fifo[m_head]];
					m_known = 1;
				end
			end
			CMD_QUERY: begin
				any = 0;
				for (int i = 0; i < DEPTH; i++) begin
					if (!m_valid[i]) continue;
					any = 1;
					if (!m_sent[i] && (!v.fv || m_seq[i] < v.fseq)) begin
						v.fv = 1;
						v.fseq = m_seq[i];
						v.fbytes = m_bytes[i];
					end
				end
				bud = m_budget < MIN_BUDGET_MS ? MIN_BUDGET_MS : m_budget;
				if (m_known && c.now > m_oldest) begin
					el = c.now - m_oldest;
					space = el >= bud ? 32'(STALE_WIN_MS) : bud - el[31:0];
				end else
					space = bud - 1;
				if (any && m_total > 0) v.kbps = ({8'd0, m_total} * 8) / space;
				v.empty = !any;
				v.total = m_total;
				v.oldest = m_known ? m_oldest : c.now;
			end
			default: ;
		endcase
		return v;
	endfunction

	// compare each accepted result against the oldest expectation
	always @(posedge clk) begin
		queue_view_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_views.size() == 0) begin
				$display("unexpected result item at %0t", $time);
				errors++;
			end else begin
				w = pending_views.pop_front();
				if (status != w.st) report("status", status, w.st);
				if (front_valid != w.fv) report("front_valid", front_valid, w.fv);
				if (front_seq != w.fseq) report("front_seq", front_seq, w.fseq);
				if (front_bytes != w.fbytes) report("front_bytes", front_bytes, w.fbytes);
				if (queue_empty != w.empty) report("queue_empty", queue_empty, w.empty);
				if (total_bytes != w.total) report("total_bytes", total_bytes, w.total);
				if (oldest_ms != w.oldest) report("oldest_ms", oldest_ms, w.oldest);
				if (target_kbps != w.kbps) report("target_kbps", target_kbps, w.kbps);
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request, none at the end
	initial begin
		int n;
		@(posedge clk iff arst_n);
		forever begin
			if (long_hold) begin
				out_stall <= 1;
				repeat (600) @(posedge clk);
				out_stall <= 0;
				long_hold = 0;
				@(posedge clk);
			end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 12);
				out_stall <= 1;
				repeat (n) @(posedge clk);
				out_stall <= 0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else
				@(posedge clk);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("pacing_queue_rate_tracker_top_tb: FAIL");
			$finish;
		end
	end

	// offer one item and hold it until accepted; valid drops only before idling
	task automatic send_item(pkt_cmd_t c, bit gaps);
		if (gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		command <= c.cmd;
		seq_number <= c.seq;
		packet_bytes <= c.nbytes;
		queue_ts <= c.qts;
		now_ms <= c.now;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_views.push_back(predict_view(c));
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_views.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_budget(logic [15:0] b);
		drain();
		cfg_data <= b;
		cfg_write <= 1;
		@(posedge clk);
		cfg_write <= 0;
		m_budget = b;
		@(posedge clk);
	endtask

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// random item biased toward a small key pool so that hits dominate
	function automatic pkt_cmd_t rand_item(logic [31:0] base, logic [47:0] t);
		pkt_cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		c.cmd = r < 45 ? CMD_PUSH : r < 80 ? CMD_SENT : r < 97 ? CMD_QUERY : CMD_NONE;
		c.seq = $urandom_range(0, 19) == 0 ? $urandom : base + $urandom_range(0, 80);
		c.nbytes = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1500));
		c.qts = $urandom_range(0, 19) == 0 ? rand48() : t + $urandom_range(0, 100);
		c.now = $urandom_range(0, 19) == 0 ? rand48() : t + $urandom_range(0, 3000);
		return c;
	endfunction

	localparam logic [47:0] TMAX = '1;
	localparam queue_view_t V_OK = '{ST_OK, 0, 0, 0, 0, 0, 0, 0};

	dir_row_t dir_rows [] = '{
		// query after reset: empty, oldest follows now
		'{'{CMD_QUERY, 0, 0, 0, 48'd1234}, 1, '{ST_OK, 0, 0, 0, 1, 0, 48'd1234, 0}},
		'{'{CMD_SENT, 32'd7, 0, 0, 0}, 1, '{ST_NOTFOUND, 0, 0, 0, 0, 0, 0, 0}},
		'{'{CMD_NONE, '1, '1, TMAX, TMAX}, 1, V_OK},
		'{'{CMD_PUSH, '1, '1, TMAX, 0}, 1, V_OK},
		'{'{CMD_PUSH, 0, 16'd0, 0, 0}, 1, V_OK},
		'{'{CMD_PUSH, '1, 16'd5, 48'd3, 0}, 1, '{ST_DUP, 0, 0, 0, 0, 0, 0, 0}},
		'{'{CMD_QUERY, 0, 0, 0, TMAX}, 0, V_OK},
		'{'{CMD_QUERY, 0, 0, 0, 0}, 0, V_OK},
		'{'{CMD_SENT, '1, 0, 0, 0}, 1, V_OK},
		'{'{CMD_QUERY, 0, 0, 0, 48'd10}, 0, V_OK},
		'{'{CMD_PUSH, '1, 16'd9, 48'd50, 0}, 1, V_OK},
		'{'{CMD_SENT, '1, 0, 0, 0}, 1, V_OK},
		'{'{CMD_SENT, '1, 0, 0, 0}, 1, V_OK},
		'{'{CMD_QUERY, 0, 0, 0, 48'd2100}, 0, V_OK},
		'{'{CMD_SENT, 0, 0, 0, 0}, 1, V_OK},
		'{'{CMD_QUERY, 0, 0, 0, 48'd5}, 1, '{ST_OK, 0, 0, 0, 1, 0, 48'd5, 0}},
		'{'{CMD_PUSH, 32'h5555_AAAA, 16'hAAAA, 48'h5555_AAAA_5555, 48'hAAAA_5555_AAAA}, 1, V_OK},
		'{'{CMD_QUERY, 0, 0, 0, 48'hAAAA_5555_AAAA}, 0, V_OK}
	};

	initial begin
		pkt_cmd_t c;
		queue_view_t got;
		logic [31:0] base;
		logic [47:0] t;
		m_budget = BUDGET_RESET;
		clear_queue();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table: typed-in rows also cross-check the model
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].c, 0);
			if (dir_rows[i].fixed) begin
				got = pending_views[$];
				if (got != dir_rows[i].v) begin
					$display("directed row %0d disagrees with typed expectation", i);
					errors++;
				end
				pending_views[$] = dir_rows[i].v;
			end
		end

		// fill the table past capacity: table full status
		for (int i = 0; i < DEPTH + 2; i++)
			send_item('{CMD_PUSH, 32'(1000 + i), 16'hFFFF, 48'(i), 0}, 0);
		send_item('{CMD_QUERY, 0, 0, 0, 48'd40}, 0);

		// long receiver hold-off while items keep coming
		long_hold = 1;
		for (int i = 0; i < DEPTH + 2; i++)
			send_item('{CMD_SENT, 32'(1000 + i), 0, 0, 0}, 0);
		send_item('{CMD_QUERY, 0, 0, 0, 48'd40}, 0);

		// random phases over several budgets, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			// sender pauses until every result is in, then the budget changes
			case (ph)
				0: write_budget(16'd0);
				1: write_budget(16'hFFFF);
				2: write_budget(16'd1);
				3: write_budget(16'd2);
				4: write_budget(16'($urandom_range(3, 5000)));
				default: write_budget(BUDGET_RESET);
			endcase
			if (ph == 5) rx_quiet = 1;
			base = $urandom;
			t = rand48() >> 2;
			for (int i = 0; i < 250; i++) begin
				c = rand_item(base, t);
				t = t + $urandom_range(0, 50);
				send_item(c, ph != 5);
			end
		end
		drain();
		if (errors == 0)
			$display("pacing_queue_rate_tracker_top_tb: PASS");
		else
			$display("pacing_queue_rate_tracker_top_tb: FAIL");
		$finish;
	end
endmodule

// ----- filelist.f -----
hdl/pqrt_pkg.sv
hdl/pqrt_ram.sv
hdl/pacing_queue_rate_tracker_top.sv
tb/pacing_queue_rate_tracker_top_tb.sv
